// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Depends on nothing; define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop at every rising clock edge, skipped while the reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)

`define ASSERT_ALL(lbl, clk, prop, msg)

`endif

`endif

// File: hw/rtl/spq_pkg.sv
// Package for the stable priority queue: sizes, operation and status codes,
// beat payloads and the stored entry format. Depends on nothing.
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W       = CNT_W + 1;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned PRIO_W      = 8;
  localparam int unsigned FILL_W      = 5;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]         item_priority;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic                      out_valid;
    logic signed [VALUE_W-1:0] out_value;
    logic [PRIO_W-1:0]         out_priority;
    logic [FILL_W-1:0]         fill_count;
  } rsp_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

// File: hw/rtl/spq_if.sv
// Valid/ready channel interfaces for the stable priority queue.
// Depends on spq_pkg for the payload types.
interface spq_req_if;
  import spq_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/stable_priority_queue.sv
// A failed beat (dequeue when empty, enqueue when full) finishes straight from idle; a dequeue
// reads the head and then hands it out; an enqueue walks from the tail, moving each held entry
// of higher priority number up one slot, then places the new entry. One memory access of each
// kind per cycle: the insertion walk moves one entry per cycle. The next request is taken only
// once a result sits in the output register; a result that must wait parks and holds the input.
// Reset (rst_ni low, async) empties the queue at once.
module stable_priority_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  // Sequencer states: take a request, read the head, walk the tail, place the new entry,
  // park a finished result while the output register is still occupied.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DEQ   = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_PUT   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // Entries live in a ring: logical slot k sits at physical (head + k) mod depth,
  // sorted by priority number from the head, ties in arrival order.
  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  k_q, k_d;          // logical slot the walk writes next
  logic [VALUE_W-1:0] item_val_q;
  logic [PRIO_W-1:0] item_pri_q;

  rsp_t rsp_q, pend_q, fin_rsp;
  logic rsp_valid_q;
  logic out_free;
  logic finish;
  logic accept;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  // Map a logical slot to its physical address; offsets stay below twice the depth.
  function automatic logic [IDX_W-1:0] phys(logic [IDX_W-1:0] base, logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  assign req_i.ready   = (state_q == ST_IDLE);
  assign accept        = req_i.valid && (state_q == ST_IDLE);
  assign out_free      = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    k_d       = k_q;
    finish    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = phys(head_q, k_q);
    mem_raddr = head_q;
    mem_wdata = '{prio: item_pri_q, value: item_val_q};

    fin_rsp.status       = STATUS_OK;
    fin_rsp.out_valid    = 1'b0;
    fin_rsp.out_value    = '0;
    fin_rsp.out_priority = '0;
    fin_rsp.fill_count   = FILL_W'(count_q);

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.payload.op == OP_DEQ) begin
            if (count_q == '0) begin
              // Nothing to hand out: flag and keep the queue as it is.
              finish         = 1'b1;
              fin_rsp.status = STATUS_EMPTY;
            end else begin
              mem_raddr = head_q;
              state_d   = ST_DEQ;
            end
          end else begin
            if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              // Drop the entry and flag it.
              finish         = 1'b1;
              fin_rsp.status = STATUS_FULL;
            end else if (count_q == '0) begin
              k_d     = '0;
              state_d = ST_PUT;
            end else begin
              // Start the walk at the tail.
              k_d       = count_q;
              mem_raddr = phys(head_q, count_q - CNT_W'(1));
              state_d   = ST_SHIFT;
            end
          end
        end
      end

      ST_DEQ: begin
        // Head entry arrived from the memory: hand it out and advance the head.
        finish               = 1'b1;
        fin_rsp.out_valid    = 1'b1;
        fin_rsp.out_value    = rdata_q.value;
        fin_rsp.out_priority = rdata_q.prio;
        fin_rsp.fill_count   = FILL_W'(count_q - CNT_W'(1));
        head_d               = phys(head_q, CNT_W'(1));
        count_d              = count_q - CNT_W'(1);
      end

      ST_SHIFT: begin
        mem_we = 1'b1;
        if (rdata_q.prio > item_pri_q) begin
          // Move the entry below up one slot and read the next one down.
          mem_wdata = rdata_q;
          k_d       = k_q - CNT_W'(1);
          mem_raddr = phys(head_q, k_q - CNT_W'(2));
          if (k_q == CNT_W'(1)) begin
            state_d = ST_PUT;
          end
        end else begin
          // Equal or lower number stays ahead: the new entry goes right after it.
          finish             = 1'b1;
          count_d            = count_q + CNT_W'(1);
          fin_rsp.fill_count = FILL_W'(count_q + CNT_W'(1));
        end
      end

      ST_PUT: begin
        mem_we             = 1'b1;
        finish             = 1'b1;
        count_d            = count_q + CNT_W'(1);
        fin_rsp.fill_count = FILL_W'(count_q + CNT_W'(1));
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_d = out_free ? ST_IDLE : ST_DONE;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      k_q         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      k_q     <= k_d;
      if ((finish || state_q == ST_DONE) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request fields, output beat and the parked result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_val_q <= req_i.payload.item_value;
      item_pri_q <= req_i.payload.item_priority;
    end
    if (finish && out_free) begin
      rsp_q <= fin_rsp;
    end else if (state_q == ST_DONE && out_free) begin
      rsp_q <= pend_q;
    end
    if (finish && !out_free) begin
      pend_q <= fin_rsp;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_RST(a_count_bound, clk_i, rst_ni,
              count_q <= CNT_W'(QUEUE_DEPTH),
              "count above depth")
  `ASSERT_RST(a_full_keeps, clk_i, rst_ni,
              accept && req_i.payload.op == OP_ENQ && count_q == CNT_W'(QUEUE_DEPTH)
              |=> count_q == $past(count_q) && head_q == $past(head_q),
              "refused enqueue changed the queue")
  `ASSERT_RST(a_deq_pop, clk_i, rst_ni,
              state_q == ST_DEQ |=> count_q == $past(count_q) - CNT_W'(1),
              "dequeue did not drop one entry")
  `ASSERT_RST(a_walk_slot, clk_i, rst_ni,
              state_q == ST_SHIFT |-> k_q != '0,
              "insertion walk ran past the head")

endmodule

// File: sim/stable_priority_queue_tb.sv
// Self-checking testbench for stable_priority_queue: random and directed enqueue and
// dequeue beats, checked against a sorted-list prediction of the queue contents.
// Depends on spq_pkg and the spq_req_if / spq_rsp_if channel interfaces.
`timescale 1ns / 100ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  logic clk_i;
  logic rst_ni;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  stable_priority_queue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted queue contents, head at index 0, kept sorted by priority number.
  logic [VALUE_W-1:0] held_value [QUEUE_DEPTH];
  logic [PRIO_W-1:0]  held_prio  [QUEUE_DEPTH];
  int unsigned        held_count;

  // Responses predicted for accepted requests, oldest first.
  rsp_t outcome_fifo [$];

  int unsigned mismatch_count;
  int unsigned rsp_seen;

  // Traffic shaping knobs, changed by the test tasks.
  bit sender_gaps_on;
  bit rsp_stalls_on;
  int hold_left;   // long receiver hold-off, counted down by the receiver process
  int stall_left;  // short random receiver stall

  // Apply one request to the predicted queue and return the response it must produce.
  function automatic rsp_t apply_queue_op(req_t r);
    rsp_t        o;
    int unsigned pos;
    int unsigned i;
    o = '0;
    o.status = STATUS_OK;
    if (r.op == OP_ENQ) begin
      if (held_count >= QUEUE_DEPTH) begin
        o.status = STATUS_FULL;
      end else begin
        // Land after every entry of lower or equal priority number, so ties stay FIFO.
        pos = 0;
        while (pos < held_count && held_prio[pos] <= r.item_priority) pos++;
        for (i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = r.item_value;
        held_prio[pos]  = r.item_priority;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        o.status = STATUS_EMPTY;
      end else begin
        o.out_valid    = 1'b1;
        o.out_value    = held_value[0];
        o.out_priority = held_prio[0];
        for (i = 1; i < held_count; i++) begin
          held_value[i-1] = held_value[i];
          held_prio[i-1]  = held_prio[i];
        end
        held_count--;
      end
    end
    o.fill_count = FILL_W'(held_count);
    return o;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] rsp beat %0d: %s got %0h, want %0h", $time, rsp_seen, name, got, want);
    mismatch_count++;
  endtask

  // Drop valid and drive junk on the payload, then idle.
  task automatic idle_req(input int n);
    req_bus.valid   <= 1'b0;
    req_bus.payload <= req_t'({$urandom, $urandom});
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one beat, hold it until accepted, then record its predicted response.
  task automatic send_beat(input op_e op, input logic [VALUE_W-1:0] value,
                           input logic [PRIO_W-1:0] prio);
    req_t r;
    r.op            = op;
    r.item_value    = value;
    r.item_priority = prio;
    req_bus.valid   <= 1'b1;
    req_bus.payload <= r;
    do @(posedge clk_i); while (!req_bus.ready);
    outcome_fifo.push_back(apply_queue_op(r));
    // Keep valid high for back-to-back beats; only lower it when idling.
    if (sender_gaps_on && $urandom_range(0, 3) == 0) idle_req($urandom_range(1, 17));
  endtask

  // Random beat: enq_pct percent enqueues, priorities half the time in a narrow band for ties.
  task automatic send_random(input int enq_pct);
    op_e             op;
    logic [PRIO_W-1:0] prio;
    int              pick;
    op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
    pick = $urandom_range(0, 99);
    if (pick < 50)      prio = PRIO_W'($urandom_range(0, 3));
    else if (pick < 80) prio = PRIO_W'($urandom);
    else if (pick < 90) prio = ($urandom_range(0, 1) == 0) ? '0 : '1;
    else                prio = PRIO_W'($urandom_range(120, 135));
    send_beat(op, $urandom, prio);
  endtask

  task automatic wait_drained();
    while (outcome_fifo.size() != 0) @(posedge clk_i);
  endtask

  // Empty dequeue, extreme values and priorities, ties, head insert, full refusal.
  task automatic test_directed();
    sender_gaps_on = 1'b1;
    rsp_stalls_on  = 1'b1;
    send_beat(OP_DEQ, 32'h0, 8'h00);          // empty queue
    send_beat(OP_ENQ, 32'h7fff_ffff, 8'd8);
    send_beat(OP_ENQ, 32'h8000_0000, 8'd8);   // tie: must follow the previous one
    send_beat(OP_ENQ, 32'h0000_0000, 8'd255);
    send_beat(OP_ENQ, 32'hffff_ffff, 8'd0);   // new head
    send_beat(OP_ENQ, 32'h0000_0005, 8'd8);
    send_beat(OP_ENQ, 32'h0000_0006, 8'd255);
    send_beat(OP_ENQ, 32'h0000_0007, 8'd0);
    send_beat(OP_ENQ, 32'haaaa_aaaa, 8'd128);
    send_beat(OP_ENQ, 32'h5555_5555, 8'd1);
    send_beat(OP_ENQ, 32'h0000_0011, 8'd254);
    send_beat(OP_ENQ, 32'h0000_0012, 8'd8);
    send_beat(OP_ENQ, 32'h0000_0013, 8'd0);
    send_beat(OP_ENQ, 32'h0000_0014, 8'd255);
    send_beat(OP_ENQ, 32'h0000_0015, 8'd127);
    send_beat(OP_ENQ, 32'h0000_0016, 8'd128);
    send_beat(OP_ENQ, 32'h0000_0017, 8'd8);   // sixteenth entry: queue now full
    send_beat(OP_ENQ, 32'h0000_0018, 8'd0);   // refused
    repeat (4) send_beat(OP_DEQ, $urandom, PRIO_W'($urandom));
    send_beat(OP_ENQ, 32'h0000_0019, 8'd0);   // lands at the head again
  endtask

  // Chunks that lean toward filling, draining or balance, with idling switched per chunk.
  task automatic test_random_mix();
    int lean [7];
    int c;
    lean = '{75, 30, 50, 90, 15, 50, 60};
    for (c = 0; c < 7; c++) begin
      sender_gaps_on = $urandom_range(0, 2) != 0;
      rsp_stalls_on  = $urandom_range(0, 2) != 0;
      repeat (50) send_random(lean[c]);
    end
  endtask

  // Hold the response side off so the output register and parked result fill and the block stalls
  // its input, then let the sender wait for every outstanding response before moving on.
  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    rsp_stalls_on  = 1'b1;
    hold_left      = 400;
    repeat (40) send_random(60);
    req_bus.valid <= 1'b0;
    wait_drained();
  endtask

  // Last stretch: full rate on both sides.
  task automatic test_full_rate();
    sender_gaps_on = 1'b0;
    rsp_stalls_on  = 1'b0;
    repeat (150) send_random(50);
  endtask

  // Response side: long hold-off first, then short random stalls, otherwise ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left--;
    end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left = $urandom_range(1, 17) - 1;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Compare every accepted response beat with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got = rsp_bus.payload;
      if (outcome_fifo.size() == 0) begin
        flag_field("beat with nothing outstanding", 32'd1, 32'd0);
      end else begin
        want = outcome_fifo.pop_front();
        if (got.status !== want.status)
          flag_field("status", 32'(got.status), 32'(want.status));
        if (got.out_valid !== want.out_valid)
          flag_field("out_valid", 32'(got.out_valid), 32'(want.out_valid));
        if (got.out_value !== want.out_value)
          flag_field("out_value", 32'(got.out_value), 32'(want.out_value));
        if (got.out_priority !== want.out_priority)
          flag_field("out_priority", 32'(got.out_priority), 32'(want.out_priority));
        if (got.fill_count !== want.fill_count)
          flag_field("fill_count", 32'(got.fill_count), 32'(want.fill_count));
      end
      rsp_seen++;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    rsp_bus.ready   = 1'b0;
    held_count      = 0;
    mismatch_count  = 0;
    rsp_seen        = 0;
    sender_gaps_on  = 1'b0;
    rsp_stalls_on   = 1'b0;
    hold_left       = 0;
    stall_left      = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix();
    test_backpressure();
    test_full_rate();

    req_bus.valid <= 1'b0;
    wait_drained();
    // Give the block time after draining to show stray response beats.
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("stable_priority_queue_tb: clean");
    end else begin
      $display("stable_priority_queue_tb: errors");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run.
  initial begin
    #2000000;
    $display("timeout with %0d responses outstanding", outcome_fifo.size());
    $display("stable_priority_queue_tb: errors");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/stable_priority_queue.sv
sim/stable_priority_queue_tb.sv
